### rtl/two_level_page_table_manager_core_assert.svh
// Assertion macros for the page table manager core.
// Expects clk and arst_n in the scope of use.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_CORE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_CORE_ASSERT_SVH

// same-cycle implication
`define TLPTM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLPTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tlptm_pkg.sv
// Shared types and constants for the two-level page table manager.
// No dependencies.
`timescale 1ns / 1ps

package tlptm_pkg;

	localparam int VPN_W           = 20;
	localparam int FRAME_W         = 20;
	localparam int FLAGS_W         = 12;
	localparam int IDX_W           = 10;
	localparam int TBL_LEN         = 1024;
	localparam int DIR_ENTRIES     = 1024;
	localparam int WORD_W          = FRAME_W + FLAGS_W;
	localparam int TABLE_SLOTS_DEF = 16;

	typedef enum logic [1:0] {
		ACT_MAP         = 2'd0,
		ACT_XLATE       = 2'd1,
		ACT_UNMAP_PAGE  = 2'd2,
		ACT_UNMAP_TABLE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_TABLE  = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

	typedef struct packed {
		action_t              action;
		logic [VPN_W-1:0]     virt_page;
		logic [FRAME_W-1:0]   phys_frame;
		logic [FLAGS_W-1:0]   entry_flags_in;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [FRAME_W-1:0]   frame_out;
		logic [FLAGS_W-1:0]   flags_out;
	} rsp_t;

	typedef enum logic [1:0] {
		TW_CLEAR     = 2'd0,
		TW_MAP_DIR   = 2'd1,
		TW_MAP_ALLOC = 2'd2,
		TW_ZERO_DIR  = 2'd3
	} tbl_wsel_t;

	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_NO_TABLE  = 2'd1,
		RS_POOL_FULL = 2'd2,
		RS_XLATE     = 2'd3
	} rsp_sel_t;

	typedef struct packed {
		logic       req_take;
		logic       dir_we;
		logic       dir_init;
		logic       dir_set;
		logic       tbl_re;
		logic       tbl_we;
		tbl_wsel_t  tbl_wsel;
		logic       sweep_inc;
		logic       scan_clr;
		logic       scan_inc;
		logic       slot_take;
		logic       slot_free;
		logic       rsp_load;
		rsp_sel_t   rsp_sel;
	} tlptm_cmd_t;

	typedef struct packed {
		action_t    action;
		logic       present;
		logic       used_at_scan;
		logic       scan_last;
		logic       sweep_last;
		logic       rsp_free;
	} tlptm_sts_t;

endpackage

### rtl/two_level_page_table_manager_core.sv
// Two-level page table manager core: controller plus datapath, uses tlptm_pkg.
// A request reads the directory and then loads its result; a translate first reads the
// table, and a map that allocates a table first scans the slots for a free one and clears
// that table. No new request is taken until the result is loaded, and a load waits while
// the result register is held by rsp_stall. Reset runs a directory clearing pass with
// req_stall high.
`timescale 1ns / 1ps
`include "two_level_page_table_manager_core_assert.svh"

module two_level_page_table_manager_core import tlptm_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	tlptm_cmd_t cmd;
	tlptm_sts_t sts;

	tlptm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlptm_dpath #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cmd      (cmd),
		.sts      (sts)
	);

	`TLPTM_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "not busy after request")
	`TLPTM_ASSERT_NOW(a_load_needs_room, cmd.rsp_load, sts.rsp_free, "result overwritten")
	`TLPTM_ASSERT_NOW(a_init_blocks_req, cmd.dir_init, req_stall, "request taken during init")

endmodule

### rtl/tlptm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tlptm_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/tlptm_ctrl.sv
// Controller state machine sequencing directory and table accesses.
// Depends on tlptm_pkg.
`timescale 1ns / 1ps

module tlptm_ctrl import tlptm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  tlptm_sts_t sts,
	output tlptm_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIR,
		S_TBL,
		S_SCAN,
		S_CLEAR,
		S_MAP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.dir_we    = 1'b1;
				cmd.dir_init  = 1'b1;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_take = 1'b1;
					state_d      = S_DIR;
				end
			end
			S_DIR: begin
				if (!sts.present) begin
					if (sts.action == ACT_MAP) begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end else if (sts.rsp_free) begin
						cmd.rsp_load = 1'b1;
						cmd.rsp_sel  = RS_NO_TABLE;
						state_d      = S_IDLE;
					end
				end else begin
					unique case (sts.action)
						ACT_XLATE: begin
							cmd.tbl_re = 1'b1;
							state_d    = S_TBL;
						end
						ACT_MAP: begin
							if (sts.rsp_free) begin
								cmd.tbl_we   = 1'b1;
								cmd.tbl_wsel = TW_MAP_DIR;
								cmd.rsp_load = 1'b1;
								cmd.rsp_sel  = RS_OK;
								state_d      = S_IDLE;
							end
						end
						ACT_UNMAP_PAGE: begin
							if (sts.rsp_free) begin
								cmd.tbl_we   = 1'b1;
								cmd.tbl_wsel = TW_ZERO_DIR;
								cmd.rsp_load = 1'b1;
								cmd.rsp_sel  = RS_OK;
								state_d      = S_IDLE;
							end
						end
						ACT_UNMAP_TABLE: begin
							if (sts.rsp_free) begin
								cmd.slot_free = 1'b1;
								cmd.dir_we    = 1'b1;
								cmd.rsp_load  = 1'b1;
								cmd.rsp_sel   = RS_OK;
								state_d       = S_IDLE;
							end
						end
						default: ;
					endcase
				end
			end
			S_TBL: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					cmd.rsp_sel  = RS_XLATE;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!sts.used_at_scan) begin
					cmd.slot_take = 1'b1;
					state_d       = S_CLEAR;
				end else if (sts.scan_last) begin
					if (sts.rsp_free) begin
						cmd.rsp_load = 1'b1;
						cmd.rsp_sel  = RS_POOL_FULL;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			S_CLEAR: begin
				cmd.tbl_we    = 1'b1;
				cmd.tbl_wsel  = TW_CLEAR;
				cmd.sweep_inc = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_MAP;
				end
			end
			S_MAP: begin
				if (sts.rsp_free) begin
					cmd.tbl_we   = 1'b1;
					cmd.tbl_wsel = TW_MAP_ALLOC;
					cmd.dir_we   = 1'b1;
					cmd.dir_set  = 1'b1;
					cmd.rsp_load = 1'b1;
					cmd.rsp_sel  = RS_OK;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

### rtl/tlptm_dpath.sv
// Datapath: directory and table memories, slot pool, counters, result register.
// Depends on tlptm_pkg and tlptm_ram.
`timescale 1ns / 1ps

module tlptm_dpath import tlptm_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  tlptm_cmd_t cmd,
	output tlptm_sts_t sts
);

	localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int DIR_W     = SLOT_W + 1;
	localparam int TBL_AW    = SLOT_W + IDX_W;
	localparam int TBL_DEPTH = TABLE_SLOTS * TBL_LEN;

	req_t                   req_q;
	logic [IDX_W-1:0]       cnt_q;
	logic [SLOT_W-1:0]      scan_q;
	logic [SLOT_W-1:0]      alloc_q;
	logic [TABLE_SLOTS-1:0] used_q;
	rsp_t                   rsp_q;
	rsp_t                   rsp_d;
	logic                   rsp_valid_q;

	logic [IDX_W-1:0]  di_q;
	logic [IDX_W-1:0]  ti_q;
	logic [WORD_W-1:0] map_word;

	logic [IDX_W-1:0]  dir_waddr;
	logic [DIR_W-1:0]  dir_wdata;
	logic [DIR_W-1:0]  dir_rdata;
	logic [SLOT_W-1:0] dir_slot;

	logic [TBL_AW-1:0] tbl_waddr;
	logic [WORD_W-1:0] tbl_wdata;
	logic [WORD_W-1:0] tbl_rdata;
	logic              rsp_free;

	assign di_q     = req_q.virt_page[VPN_W-1 -: IDX_W];
	assign ti_q     = req_q.virt_page[IDX_W-1:0];
	assign map_word = {req_q.phys_frame, req_q.entry_flags_in};
	assign dir_slot = dir_rdata[SLOT_W-1:0];

	assign dir_waddr = cmd.dir_init ? cnt_q : di_q;
	assign dir_wdata = cmd.dir_set ? {1'b1, alloc_q} : '0;

	tlptm_ram #(
		.WIDTH (DIR_W),
		.DEPTH (DIR_ENTRIES),
		.ADDR_W(IDX_W)
	) u_dir_ram (
		.clk  (clk),
		.we   (cmd.dir_we),
		.waddr(dir_waddr),
		.wdata(dir_wdata),
		.re   (cmd.req_take),
		.raddr(req.virt_page[VPN_W-1 -: IDX_W]),
		.rdata(dir_rdata)
	);

	always_comb begin
		unique case (cmd.tbl_wsel)
			TW_CLEAR: begin
				tbl_waddr = {alloc_q, cnt_q};
				tbl_wdata = '0;
			end
			TW_MAP_DIR: begin
				tbl_waddr = {dir_slot, ti_q};
				tbl_wdata = map_word;
			end
			TW_MAP_ALLOC: begin
				tbl_waddr = {alloc_q, ti_q};
				tbl_wdata = map_word;
			end
			TW_ZERO_DIR: begin
				tbl_waddr = {dir_slot, ti_q};
				tbl_wdata = '0;
			end
			default: begin
				tbl_waddr = {dir_slot, ti_q};
				tbl_wdata = '0;
			end
		endcase
	end

	tlptm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TBL_DEPTH),
		.ADDR_W(TBL_AW)
	) u_tbl_ram (
		.clk  (clk),
		.we   (cmd.tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (cmd.tbl_re),
		.raddr({dir_slot, ti_q}),
		.rdata(tbl_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.req_take) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			scan_q  <= '0;
			alloc_q <= '0;
			used_q  <= '0;
		end else begin
			if (cmd.sweep_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.scan_clr) begin
				scan_q <= '0;
			end else if (cmd.scan_inc) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.slot_take) begin
				used_q[scan_q] <= 1'b1;
				alloc_q        <= scan_q;
			end
			if (cmd.slot_free) begin
				used_q[dir_slot] <= 1'b0;
			end
		end
	end

	// result register, refilled only when empty or being taken
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rsp_d = '0;
		unique case (cmd.rsp_sel)
			RS_OK:        rsp_d.status = ST_OK;
			RS_NO_TABLE:  rsp_d.status = ST_NO_TABLE;
			RS_POOL_FULL: rsp_d.status = ST_POOL_FULL;
			RS_XLATE: begin
				rsp_d.status    = ST_OK;
				rsp_d.frame_out = tbl_rdata[WORD_W-1 -: FRAME_W];
				rsp_d.flags_out = tbl_rdata[FLAGS_W-1:0];
			end
			default:      rsp_d.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign sts.action       = req_q.action;
	assign sts.present      = dir_rdata[SLOT_W];
	assign sts.used_at_scan = used_q[scan_q];
	assign sts.scan_last    = (scan_q == SLOT_W'(TABLE_SLOTS - 1));
	assign sts.sweep_last   = &cnt_q;
	assign sts.rsp_free     = rsp_free;

endmodule
